// ----- hw/rtl/a2s_pkg.sv -----
package a2s_pkg;

  localparam int unsigned NUM_ESC_KEYS = 13;

  localparam logic [7:0] EXEC_CODE = 8'hB2;
  localparam logic [7:0] CARET     = 8'h5E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_E      = 8'h45;

  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_PAUSE = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] key_code;
    logic       parity;
    logic [3:0] pause_units;
  } res_t;

  typedef struct packed {
    logic [7:0] first_ch;
    logic [7:0] second_ch;
    logic [7:0] code;
  } esc_key_t;

  // lower half of the character rom, upper half reads as zero
  localparam logic [7:0] ROM_LO [128] = '{
    8'h00,8'hDF,8'h91,8'h00,8'h00,8'h00,8'h00,8'h93,
    8'h34,8'h00,8'h00,8'h00,8'h36,8'hB2,8'h00,8'h34,
    8'hB4,8'h00,8'h96,8'h00,8'h95,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h4F,8'hB6,8'h00,8'h00,8'h00,8'h00,
    8'h39,8'h00,8'h4C,8'h30,8'h4B,8'h00,8'h4A,8'hFA,
    8'h3A,8'hBA,8'h9D,8'h99,8'hF9,8'h9B,8'h89,8'h00,
    8'h8F,8'h4D,8'h0F,8'hCF,8'hAF,8'h2F,8'hEF,8'h6F,
    8'h7F,8'hFF,8'h88,8'hF8,8'hCE,8'h32,8'h6E,8'h0C,
    8'h70,8'h0B,8'hE9,8'hA9,8'hAB,8'hAD,8'h2B,8'hEB,
    8'h6B,8'hFD,8'h7B,8'hFB,8'h8B,8'h79,8'h69,8'h8D,
    8'h3D,8'h0D,8'h2D,8'hCB,8'hED,8'h7D,8'h29,8'hCD,
    8'hC9,8'h6D,8'h09,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h0B,8'hE9,8'hA9,8'hAB,8'hAD,8'h2B,8'hEB,
    8'h6B,8'hFD,8'h7B,8'hFB,8'h8B,8'h79,8'h69,8'h8D,
    8'h3D,8'h0D,8'h2D,8'hCB,8'hED,8'h7D,8'h29,8'hCD,
    8'hC9,8'h6D,8'h09,8'h00,8'h00,8'h00,8'h96,8'h34
  };

  localparam esc_key_t ESC_KEYS [NUM_ESC_KEYS] = '{
    '{8'h4C, 8'h45, 8'h34},  // LE
    '{8'h52, 8'h49, 8'hB4},  // RI
    '{8'h55, 8'h50, 8'hDF},  // UP
    '{8'h44, 8'h4F, 8'h4F},  // DO
    '{8'h53, 8'h55, 8'hDE},  // SU
    '{8'h53, 8'h44, 8'h4E},  // SD
    '{8'h48, 8'h4F, 8'h36},  // HO
    '{8'h45, 8'h58, 8'hB2},  // EX
    '{8'h41, 8'h54, 8'hB6},  // AT
    '{8'h43, 8'h41, 8'h96},  // CA
    '{8'h43, 8'h50, 8'h91},  // CP
    '{8'h43, 8'h4D, 8'h93},  // CM
    '{8'h43, 8'h53, 8'h95}   // CS
  };

  function automatic logic [7:0] rom_lookup(input logic [7:0] ch);
    logic [7:0] val;
    val = ch[7] ? 8'h00 : ROM_LO[ch[6:0]];
    return val;
  endfunction

endpackage

// ----- hw/rtl/a2s_if.sv -----
interface a2s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface a2s_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] key_code;
  logic       parity;
  logic [3:0] pause_units;

  modport source (output valid, output kind, output key_code, output parity,
                  output pause_units, input ready);
  modport sink   (input valid, input kind, input key_code, input parity,
                  input pause_units, output ready);
endinterface

// ----- hw/rtl/ascii_to_scan_code_translator.sv -----
// ascii to keyboard scan code translator
//
// in_ch carries one received character per request (valid/ready). out_ch
// carries at most one result per character: a key scan code with its even
// parity bit (kind 0, code 00 for an execute switch) or a pause request of
// 1 to 9 units (kind 1). characters that map to nothing, escape characters
// being collected and suppressed execute codes produce no request on out_ch.
//
// a result is registered and appears on out_ch in the cycle after its
// character is taken. one character is taken per cycle while out_ch is not
// stalled; the rom lookup, the escape pair compare and the state update all
// sit between the input handshake and the single result register.
//
// reset (rst_n low, synchronous) returns to normal mode with execute
// enabled, clears the kept escape characters and empties the result register.
// when the receiver stalls, the result holds on out_ch and one more character
// is still taken if the result register drains in that same cycle; otherwise
// in_ch.ready drops until out_ch.ready returns.
module ascii_to_scan_code_translator (
  input  logic           clk,
  input  logic           rst_n,
  a2s_in_if.sink         in_ch,
  a2s_out_if.source      out_ch
);

  // escape state
  logic       esc_r,   esc_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] second_r, second_nxt;
  logic [1:0] cnt_r,   cnt_nxt;
  logic       exe_r,   exe_nxt;

  // result register
  logic          out_valid_r;
  a2s_pkg::res_t res_r;
  a2s_pkg::res_t res_nxt;
  logic          hit;

  logic       in_fire;
  logic [7:0] ch;
  logic [7:0] code;
  logic [7:0] f_ch;
  logic [7:0] s_ch;
  logic       pair_hit;
  logic [7:0] pair_code;

  assign ch      = in_ch.in_byte;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign code    = a2s_pkg::rom_lookup(ch);

  // kept characters as they stand after this one is stored
  assign f_ch = (cnt_r == 2'd0) ? ch : first_r;
  assign s_ch = (cnt_r == 2'd1) ? ch : second_r;

  // escape pair table, searched in order, first match wins
  always_comb begin
    pair_hit  = 1'b0;
    pair_code = 8'h00;
    for (int i = 0; i < a2s_pkg::NUM_ESC_KEYS; i++) begin
      if (!pair_hit && f_ch == a2s_pkg::ESC_KEYS[i].first_ch &&
          s_ch == a2s_pkg::ESC_KEYS[i].second_ch) begin
        pair_hit  = 1'b1;
        pair_code = a2s_pkg::ESC_KEYS[i].code;
      end
    end
  end

  always_comb begin
    esc_nxt    = esc_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    cnt_nxt    = cnt_r;
    exe_nxt    = exe_r;
    hit        = 1'b0;
    res_nxt.kind        = a2s_pkg::KIND_KEY;
    res_nxt.key_code    = 8'h00;
    res_nxt.parity      = 1'b0;
    res_nxt.pause_units = 4'd0;

    if (!esc_r) begin
      if (code != 8'h00) begin
        // execute code is dropped while execute is off
        if (!(code == a2s_pkg::EXEC_CODE && !exe_r)) begin
          hit              = 1'b1;
          res_nxt.key_code = code;
          res_nxt.parity   = ^code;
        end
      end else if (ch == a2s_pkg::CARET) begin
        esc_nxt = 1'b1;
        cnt_nxt = 2'd0;
      end
    end else begin
      first_nxt  = f_ch;
      second_nxt = s_ch;
      if (cnt_r == 2'd0) begin
        cnt_nxt = 2'd1;
      end else if (cnt_r == 2'd1) begin
        cnt_nxt = 2'd2;
      end
      if (ch == a2s_pkg::CARET) begin
        // closing caret, decode the kept pair
        esc_nxt = 1'b0;
        cnt_nxt = 2'd0;
        if (pair_hit) begin
          hit              = 1'b1;
          res_nxt.key_code = pair_code;
          res_nxt.parity   = ^pair_code;
        end else if (f_ch == a2s_pkg::CH_D && s_ch >= a2s_pkg::CH_1 &&
                     s_ch <= a2s_pkg::CH_9) begin
          hit                 = 1'b1;
          res_nxt.kind        = a2s_pkg::KIND_PAUSE;
          res_nxt.pause_units = s_ch[3:0];
        end else if (f_ch == a2s_pkg::CH_E &&
                     (s_ch == a2s_pkg::CH_0 || s_ch == a2s_pkg::CH_1)) begin
          // execute switch gives an empty key result
          hit     = 1'b1;
          exe_nxt = (s_ch == a2s_pkg::CH_1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r    <= 1'b0;
      first_r  <= 8'h00;
      second_r <= 8'h00;
      cnt_r    <= 2'd0;
      exe_r    <= 1'b1;
    end else if (in_fire) begin
      esc_r    <= esc_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      cnt_r    <= cnt_nxt;
      exe_r    <= exe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_fire && hit;
    end
  end

  // payload only loads with a new result
  always_ff @(posedge clk) begin
    if (in_fire && hit) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = res_r.kind;
  assign out_ch.key_code    = res_r.key_code;
  assign out_ch.parity      = res_r.parity;
  assign out_ch.pause_units = res_r.pause_units;

endmodule

// ----- hw/rtl/a2s_checker.sv -----
module a2s_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [7:0] key_code,
  input logic       parity,
  input logic [3:0] pause_units
);

  // parity of a key result follows its key code
  a_key_parity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind == a2s_pkg::KIND_KEY) |->
      (parity == ^key_code && pause_units == 4'd0))
    else $error("key result with bad parity or nonzero pause");

  // pause results carry 1 to 9 units and no key code
  a_pause_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && kind == a2s_pkg::KIND_PAUSE) |->
      (key_code == 8'h00 && parity == 1'b0 &&
       pause_units >= 4'd1 && pause_units <= 4'd9))
    else $error("malformed pause result");

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(kind) && $stable(key_code) &&
       $stable(parity) && $stable(pause_units)))
    else $error("stalled result changed");

endmodule

bind ascii_to_scan_code_translator a2s_checker u_a2s_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .kind        (out_ch.kind),
  .key_code    (out_ch.key_code),
  .parity      (out_ch.parity),
  .pause_units (out_ch.pause_units)
);
